// ===== src/hsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsf_pkg;

    localparam int VAL_W     = 32;
    localparam int SUM_W     = VAL_W + 3;
    localparam int LAM_W     = 15;
    localparam int PROD_W    = SUM_W + LAM_W + 1;
    localparam int FRAC_W    = 16;
    localparam int STEP_W    = 16;
    localparam int GS_W      = 8;
    localparam int POS_W     = 7;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd2;

    localparam logic [GS_W-1:0]   GRID_SIZE_RST  = 8'd128;
    localparam logic [LAM_W-1:0]  DIFF_RATIO_RST = 15'd13107;
    localparam logic [STEP_W-1:0] STEP_COUNT_RST = 16'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HREAD,
        ST_STEP,
        ST_RD,
        ST_COPY,
        ST_ACC,
        ST_MUL,
        ST_WR,
        ST_DONE
    } t_state;

    // stencil read order: center first, then the four neighbors
    typedef enum logic [2:0] {
        NB_CTR,
        NB_UP,
        NB_DOWN,
        NB_LEFT,
        NB_RIGHT
    } t_nb;

    typedef struct packed {
        logic rd;
        logic wr_even;
        logic wr_odd;
    } t_mem_ctl;

    typedef struct packed {
        logic load_u;
        logic add_nb;
        logic mul;
    } t_upd_ctl;

endpackage

`default_nettype wire

// ===== src/hsf_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hsf_req_if;
    import hsf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [VAL_W-1:0] cell_value;

    modport source (output valid, output op, output row, output col,
                    output cell_value, input ready);
    modport sink   (input valid, input op, input row, input col,
                    input cell_value, output ready);
endinterface

`default_nettype wire

// ===== src/hsf_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hsf_rsp_if;
    import hsf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic                    saturated;

    modport source (output valid, output read_value, output saturated, input ready);
    modport sink   (input valid, input read_value, input saturated, output ready);
endinterface

`default_nettype wire

// ===== src/heat_stencil_ftcs_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// i_req     in   valid/ready        op, row, col, cell_value
// o_rsp     out  valid/ready        read_value, saturated
// i_cfg_*   in   write enable only  i_cfg_idx selects grid_size/diffusion_ratio/step_count
//
// Write and read requests are answered through an output register where the response sits,
// so a new request is taken while it waits. A run request walks the grid once per step
// through the single read port of the current store: a boundary cell is read and copied,
// an interior cell takes five reads, sum, multiply and write back, and a final step check
// and the response follow the last step.
// Reset is synchronous: it clears control state and makes the even store current;
// the stores themselves hold whatever was last written.

module heat_stencil_ftcs_2d #(
    parameter int MAX_SIDE = 128
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    hsf_req_if.sink                            i_req,
    hsf_rsp_if.source                          o_rsp,
    input  wire logic                          i_cfg_we,
    input  wire logic [hsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [hsf_pkg::CFG_W-1:0]     i_cfg_data
);
    import hsf_pkg::*;

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [GS_W-1:0]   r_grid_size;
    logic [LAM_W-1:0]  r_lambda;
    logic [STEP_W-1:0] r_step_count;

    t_mem_ctl          mem;
    t_upd_ctl          upd;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [VAL_W-1:0]  wdata;
    logic [VAL_W-1:0]  rdata_even, rdata_odd, rdata;
    logic [VAL_W-1:0]  upd_val;
    logic              upd_sat;
    logic              cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size  <= GRID_SIZE_RST;
            r_lambda     <= DIFF_RATIO_RST;
            r_step_count <= STEP_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_SIZE:  r_grid_size  <= i_cfg_data[GS_W-1:0];
                CFG_DIFF_RATIO: r_lambda     <= i_cfg_data[LAM_W-1:0];
                CFG_STEP_COUNT: r_step_count <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign rdata = cur ? rdata_odd : rdata_even;

    hsf_ctrl #(
        .MAX_SIDE (MAX_SIDE),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_grid_size  (r_grid_size),
        .i_step_count (r_step_count),
        .i_rdata      (rdata),
        .i_upd_val    (upd_val),
        .i_upd_sat    (upd_sat),
        .o_mem        (mem),
        .o_raddr      (raddr),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_upd        (upd),
        .o_cur        (cur)
    );

    hsf_update u_update (
        .i_clk    (i_clk),
        .i_ctl    (upd),
        .i_rdata  (rdata),
        .i_lambda (r_lambda),
        .o_value  (upd_val),
        .o_sat    (upd_sat)
    );

    hsf_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_even (
        .i_clk   (i_clk),
        .i_we    (mem.wr_even),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (mem.rd),
        .i_raddr (raddr),
        .o_rdata (rdata_even)
    );

    hsf_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_odd (
        .i_clk   (i_clk),
        .i_we    (mem.wr_odd),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (mem.rd),
        .i_raddr (raddr),
        .o_rdata (rdata_odd)
    );

endmodule

`default_nettype wire

// ===== src/hsf_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsf_store #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [ADDR_W-1:0]         i_waddr,
    input  wire logic [hsf_pkg::VAL_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [ADDR_W-1:0]         i_raddr,
    output logic      [hsf_pkg::VAL_W-1:0] o_rdata
);
    import hsf_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/hsf_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsf_update (
    input  wire logic                             i_clk,
    input  wire hsf_pkg::t_upd_ctl                i_ctl,
    input  wire logic        [hsf_pkg::VAL_W-1:0] i_rdata,
    input  wire logic        [hsf_pkg::LAM_W-1:0] i_lambda,
    output logic             [hsf_pkg::VAL_W-1:0] o_value,
    output logic                                  o_sat
);
    import hsf_pkg::*;

    localparam int DELTA_W = PROD_W - FRAC_W;
    localparam int RES_W   = DELTA_W + 1;

    logic signed [VAL_W-1:0]   r_u;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [PROD_W-1:0]  r_prod;

    logic signed [SUM_W-1:0]   rd_ext;
    logic signed [LAM_W:0]     lam_s;
    logic signed [DELTA_W-1:0] delta;
    logic signed [RES_W-1:0]   res;
    logic                      ovf;

    assign rd_ext = SUM_W'($signed(i_rdata));
    assign lam_s  = $signed({1'b0, i_lambda});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_u) begin
            r_u   <= $signed(i_rdata);
            r_sum <= SUM_W'(0) - (rd_ext <<< 2);
        end else if (i_ctl.add_nb) begin
            r_sum <= r_sum + rd_ext;
        end
        if (i_ctl.mul) begin
            r_prod <= lam_s * r_sum;
        end
    end

    // dropping the fraction bits of a signed product rounds toward minus infinity
    assign delta = r_prod[PROD_W-1:FRAC_W];
    assign res   = RES_W'(r_u) + RES_W'(delta);
    assign ovf   = (res[RES_W-1:VAL_W-1] != '0) && (res[RES_W-1:VAL_W-1] != '1);

    always_comb begin
        if (!ovf) begin
            o_value = res[VAL_W-1:0];
        end else if (res[RES_W-1]) begin
            o_value = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            o_value = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    assign o_sat = ovf;

endmodule

`default_nettype wire

// ===== src/hsf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsf_ctrl #(
    parameter int MAX_SIDE = 128,
    parameter int ADDR_W   = 14
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    hsf_req_if.sink                         i_req,
    hsf_rsp_if.source                       o_rsp,
    input  wire logic [hsf_pkg::GS_W-1:0]   i_grid_size,
    input  wire logic [hsf_pkg::STEP_W-1:0] i_step_count,
    input  wire logic [hsf_pkg::VAL_W-1:0]  i_rdata,
    input  wire logic [hsf_pkg::VAL_W-1:0]  i_upd_val,
    input  wire logic                       i_upd_sat,
    output hsf_pkg::t_mem_ctl               o_mem,
    output logic      [ADDR_W-1:0]          o_raddr,
    output logic      [ADDR_W-1:0]          o_waddr,
    output logic      [hsf_pkg::VAL_W-1:0]  o_wdata,
    output hsf_pkg::t_upd_ctl               o_upd,
    output logic                            o_cur
);
    import hsf_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = ($clog2(MAX_SIDE + 1) > GS_W) ? $clog2(MAX_SIDE + 1) : GS_W;

    t_state              r_state, n_state;
    t_nb                 r_nb;
    logic [IDX_W-1:0]    r_row, r_col;
    logic [SIDE_W-1:0]   r_side;
    logic [STEP_W-1:0]   r_steps;
    logic                r_cur;
    logic                r_hin;
    logic                r_ovalid;
    logic [VAL_W-1:0]    r_res_val;
    logic                r_res_sat;
    logic [VAL_W-1:0]    r_out_val;
    logic                r_out_sat;

    logic                accept;
    logic                in_grid;
    logic                out_free;
    logic                load_out;
    logic [VAL_W-1:0]    load_val;
    logic                load_sat;
    logic [VAL_W-1:0]    hread_val;
    logic [SIDE_W-1:0]   side_calc;
    logic                last_col, last_row, is_edge;
    logic [IDX_W-1:0]    nb_row, nb_col;
    logic [ADDR_W-1:0]   host_addr, run_raddr, run_waddr;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
    endfunction

    assign accept    = i_req.valid && (r_state == ST_IDLE);
    assign in_grid   = ({25'd0, i_req.row} < 32'(MAX_SIDE)) &&
                       ({25'd0, i_req.col} < 32'(MAX_SIDE));
    assign out_free  = !r_ovalid || o_rsp.ready;
    assign hread_val = r_hin ? i_rdata : '0;
    assign side_calc = (SIDE_W'(i_grid_size) > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                                   : SIDE_W'(i_grid_size);
    assign last_col  = (SIDE_W'(r_col) + SIDE_W'(1)) == r_side;
    assign last_row  = (SIDE_W'(r_row) + SIDE_W'(1)) == r_side;
    assign is_edge   = (r_row == '0) || (r_col == '0) || last_col || last_row;

    always_comb begin
        nb_row = r_row;
        nb_col = r_col;
        unique case (r_nb)
            NB_UP:    nb_row = r_row - IDX_W'(1);
            NB_DOWN:  nb_row = r_row + IDX_W'(1);
            NB_LEFT:  nb_col = r_col - IDX_W'(1);
            NB_RIGHT: nb_col = r_col + IDX_W'(1);
            default:  ;
        endcase
    end

    assign host_addr = cell_addr(IDX_W'(i_req.row), IDX_W'(i_req.col));
    assign run_raddr = cell_addr(nb_row, nb_col);
    assign run_waddr = cell_addr(r_row, r_col);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req.op)
                        OP_RUN:  n_state = ST_STEP;
                        OP_READ: n_state = ST_HREAD;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_HREAD: n_state = out_free ? ST_IDLE : ST_DONE;
            ST_DONE:  n_state = out_free ? ST_IDLE : ST_DONE;
            ST_STEP: begin
                if (r_steps == '0) begin
                    n_state = ST_DONE;
                end else if (r_side != '0) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (r_nb == NB_CTR && is_edge) begin
                    n_state = ST_COPY;
                end else if (r_nb == NB_RIGHT) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_WR;
            ST_COPY,
            ST_WR:   n_state = (last_col && last_row) ? ST_STEP : ST_RD;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready = 1'b0;
        o_mem       = '0;
        o_upd       = '0;
        o_raddr     = run_raddr;
        o_waddr     = run_waddr;
        o_wdata     = i_upd_val;
        load_out    = 1'b0;
        load_val    = r_res_val;
        load_sat    = r_res_sat;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                o_raddr     = host_addr;
                o_waddr     = host_addr;
                o_wdata     = i_req.cell_value;
                if (accept && i_req.op == OP_WRITE && in_grid) begin
                    o_mem.wr_even = 1'b1;
                    o_mem.wr_odd  = 1'b1;
                end
                o_mem.rd = accept && (i_req.op == OP_READ);
            end
            ST_HREAD: begin
                load_out = out_free;
                load_val = hread_val;
                load_sat = 1'b0;
            end
            ST_DONE: load_out = out_free;
            ST_RD: begin
                o_mem.rd     = 1'b1;
                o_upd.load_u = (r_nb == NB_UP);
                o_upd.add_nb = (r_nb != NB_CTR) && (r_nb != NB_UP);
            end
            ST_COPY: begin
                o_mem.wr_even = r_cur;
                o_mem.wr_odd  = !r_cur;
                o_wdata       = i_rdata;
            end
            ST_ACC: o_upd.add_nb = 1'b1;
            ST_MUL: o_upd.mul    = 1'b1;
            ST_WR: begin
                o_mem.wr_even = r_cur;
                o_mem.wr_odd  = !r_cur;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nb     <= NB_CTR;
            r_row    <= '0;
            r_col    <= '0;
            r_side   <= '0;
            r_steps  <= '0;
            r_cur    <= 1'b0;
            r_hin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_hin   <= in_grid;
                        r_steps <= i_step_count;
                        r_side  <= side_calc;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_nb    <= NB_CTR;
                    end
                end
                ST_STEP: begin
                    // empty grid: the stores still swap once per step
                    if (r_steps != '0 && r_side == '0) begin
                        r_cur   <= !r_cur;
                        r_steps <= r_steps - STEP_W'(1);
                    end
                end
                ST_RD: begin
                    if (!(r_nb == NB_CTR && is_edge) && r_nb != NB_RIGHT) begin
                        r_nb <= t_nb'(3'(r_nb) + 3'd1);
                    end
                end
                ST_COPY,
                ST_WR: begin
                    r_nb <= NB_CTR;
                    if (last_col) begin
                        r_col <= '0;
                        if (last_row) begin
                            r_row   <= '0;
                            r_cur   <= !r_cur;
                            r_steps <= r_steps - STEP_W'(1);
                        end else begin
                            r_row <= r_row + IDX_W'(1);
                        end
                    end else begin
                        r_col <= r_col + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept) begin
            r_res_val <= '0;
            r_res_sat <= 1'b0;
        end else if (r_state == ST_HREAD && !out_free) begin
            r_res_val <= hread_val;
        end else if (r_state == ST_WR && i_upd_sat) begin
            r_res_sat <= 1'b1;
        end
        if (load_out) begin
            r_out_val <= load_val;
            r_out_sat <= load_sat;
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.read_value = r_out_val;
    assign o_rsp.saturated  = r_out_sat;
    assign o_cur            = r_cur;

    a_read_goes_hread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.op == OP_READ) |=> (r_state == ST_HREAD))
        else $error("read request did not enter the read-data state");

    a_swap_at_step_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cur) |-> ($past(r_state) == ST_WR || $past(r_state) == ST_COPY ||
                             $past(r_state) == ST_STEP))
        else $error("store roles swapped outside a step boundary");

    a_acc_after_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> ($past(r_state) == ST_RD && $past(r_nb) == NB_RIGHT))
        else $error("stencil sum finished before all neighbors were read");

    a_run_write_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR || r_state == ST_COPY) |-> (o_mem.wr_odd == !r_cur) &&
                                                    (o_mem.wr_even == r_cur))
        else $error("step write hit the current store");

endmodule

`default_nettype wire
